### rtl/core/ppi_pkg.sv
// ---------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants for the mode 0 parallel port interface.
// ---------------------------------------------------------------------------
package ppi_pkg;

  localparam int ADDR_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int STRAP_W  = 7;
  localparam int DIR_W    = 4;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  localparam logic [STRAP_W-1:0] STRAP_RESET = 7'd47;

  // Port select codes from address bits 9:8.
  localparam logic [1:0] SEL_A    = 2'd0;
  localparam logic [1:0] SEL_B    = 2'd1;
  localparam logic [1:0] SEL_C    = 2'd2;
  localparam logic [1:0] SEL_CTRL = 2'd3;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Bit positions in the direction flags; a set bit means input.
  localparam int DIR_A     = 3;
  localparam int DIR_C_UP  = 2;
  localparam int DIR_B     = 1;
  localparam int DIR_C_LOW = 0;

  localparam logic [DIR_W-1:0] DIR_RESET = 4'b0010;

  typedef struct packed {
    logic              responded;
    logic [BYTE_W-1:0] read_data;
    logic [BYTE_W-1:0] port_a_latch;
    logic [BYTE_W-1:0] port_b_latch;
    logic [BYTE_W-1:0] port_c_latch;
    logic [DIR_W-1:0]  direction_flags;
    logic              psg_select_valid;
    logic [1:0]        psg_function;
    logic              key_line_valid;
    logic [3:0]        key_line;
  } result_t;

endpackage

### rtl/core/ppi_core.sv
// ---------------------------------------------------------------------------
// ppi_core
// Direction bits and output latches, updated once for each accepted access,
// with the combinational decode that forms the result of that access.
// ---------------------------------------------------------------------------
module ppi_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             op,
  input  logic [ppi_pkg::ADDR_W-1:0]       address,
  input  logic [ppi_pkg::BYTE_W-1:0]       write_data,
  input  logic [ppi_pkg::BYTE_W-1:0]       port_a_pins,
  input  logic                             vsync,
  input  logic [ppi_pkg::STRAP_W-1:0]      strap,
  output ppi_pkg::result_t                 result
);

  logic [ppi_pkg::DIR_W-1:0]  port_directions;
  logic [ppi_pkg::BYTE_W-1:0] latch_a;
  logic [ppi_pkg::BYTE_W-1:0] latch_b;
  logic [ppi_pkg::BYTE_W-1:0] latch_c;

  logic [ppi_pkg::DIR_W-1:0]  port_directions_next;
  logic [ppi_pkg::BYTE_W-1:0] latch_a_next;
  logic [ppi_pkg::BYTE_W-1:0] latch_b_next;
  logic [ppi_pkg::BYTE_W-1:0] latch_c_next;
  logic [ppi_pkg::BYTE_W-1:0] read_data;
  logic [ppi_pkg::BYTE_W-1:0] bit_mask;
  logic [1:0]                 sel;
  logic                       claimed;
  logic                       psg_v;
  logic                       key_v;

  assign sel      = address[9:8];
  assign claimed  = ~address[11];
  assign bit_mask = ppi_pkg::BYTE_W'(1) << write_data[3:1];

  always_comb begin
    port_directions_next = port_directions;
    latch_a_next         = latch_a;
    latch_b_next         = latch_b;
    latch_c_next         = latch_c;
    read_data            = '0;
    psg_v                = 1'b0;
    key_v                = 1'b0;
    if (claimed) begin
      if (op == ppi_pkg::OP_READ) begin
        unique case (sel)
          ppi_pkg::SEL_A: begin
            if (port_directions[ppi_pkg::DIR_A]) read_data = port_a_pins;
          end
          ppi_pkg::SEL_B: begin
            if (port_directions[ppi_pkg::DIR_B]) read_data = {strap, vsync};
          end
          ppi_pkg::SEL_C: begin
            if (!port_directions[ppi_pkg::DIR_C_UP] && !port_directions[ppi_pkg::DIR_C_LOW])
              read_data = latch_c;
          end
          default: begin
            read_data = '0;
          end
        endcase
      end else begin
        unique case (sel)
          ppi_pkg::SEL_A: begin
            if (!port_directions[ppi_pkg::DIR_A]) latch_a_next = write_data;
          end
          ppi_pkg::SEL_B: begin
            if (!port_directions[ppi_pkg::DIR_B]) latch_b_next = write_data;
          end
          ppi_pkg::SEL_C: begin
            if (!port_directions[ppi_pkg::DIR_C_UP]) begin
              latch_c_next[7:4] = write_data[7:4];
              psg_v             = 1'b1;
            end
            if (!port_directions[ppi_pkg::DIR_C_LOW]) begin
              latch_c_next[3:0] = write_data[3:0];
              key_v             = 1'b1;
            end
          end
          default: begin
            if (write_data[7]) begin
              port_directions_next = {write_data[4], write_data[3],
                                      write_data[1], write_data[0]};
              latch_a_next         = '0;
              latch_b_next         = '0;
              latch_c_next         = '0;
            end else if (write_data[0]) begin
              latch_c_next = latch_c | bit_mask;
            end else begin
              latch_c_next = latch_c & ~bit_mask;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_directions <= ppi_pkg::DIR_RESET;
      latch_a         <= '0;
      latch_b         <= '0;
      latch_c         <= '0;
    end else if (accept) begin
      port_directions <= port_directions_next;
      latch_a         <= latch_a_next;
      latch_b         <= latch_b_next;
      latch_c         <= latch_c_next;
    end
  end

  always_comb begin
    result.responded        = claimed;
    result.read_data        = read_data;
    result.port_a_latch     = latch_a_next;
    result.port_b_latch     = latch_b_next;
    result.port_c_latch     = latch_c_next;
    result.direction_flags  = port_directions_next;
    result.psg_select_valid = psg_v;
    result.psg_function     = psg_v ? write_data[7:6] : 2'd0;
    result.key_line_valid   = key_v;
    result.key_line         = key_v ? write_data[3:0] : 4'd0;
  end

endmodule

### rtl/core/ppi_out.sv
// ---------------------------------------------------------------------------
// ppi_out
// Result register on the output side, holding one finished transaction until
// it is taken downstream.
// ---------------------------------------------------------------------------
module ppi_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             taken,
  input  ppi_pkg::result_t result_in,
  output logic             valid,
  output ppi_pkg::result_t result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### rtl/core/parallel_port_interface_mode0.sv
// ---------------------------------------------------------------------------
// parallel_port_interface_mode0
// Mode 0 parallel port interface: decodes one bus access per transaction,
// keeps the direction bits and port latches, and returns one result.
// ---------------------------------------------------------------------------
//  Channel      Direction  Contents
//  s_axis       in         tuser: op; tdata: address, write_data, port_a_pins, vsync
//  m_axis       out        tdata: responded .. key_line (see port comment)
//  port_b_strap in         write enable and 7-bit strap value
//
//  Each transaction passes through the combinational decode logic and is held in
//  the result register until it is taken; one transaction per cycle is sustained
//  while the receiver takes every result.
//  Reset clears the latches, sets port B as the only input and loads a strap of 47.
//  Input is taken whenever the result register is empty or being emptied.
// ---------------------------------------------------------------------------
module parallel_port_interface_mode0 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: address[15:0], write_data[23:16], port_a_pins[31:24], vsync[32], zero pad
  input  logic [ppi_pkg::IN_W-1:0]      s_axis_tdata,
  // tuser: op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: responded[0], read_data[8:1], port_a_latch[16:9], port_b_latch[24:17],
  // port_c_latch[32:25], direction_flags[36:33], psg_select_valid[37],
  // psg_function[39:38], key_line_valid[40], key_line[44:41], zero pad
  output logic [ppi_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          port_b_strap_we,
  input  logic [ppi_pkg::STRAP_W-1:0]   port_b_strap
);

  logic [ppi_pkg::STRAP_W-1:0] strap;
  logic                        accept;
  ppi_pkg::result_t            result;
  ppi_pkg::result_t            result_q;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      strap <= ppi_pkg::STRAP_RESET;
    end else if (port_b_strap_we) begin
      strap <= port_b_strap;
    end
  end

  ppi_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (s_axis_tuser),
    .address     (s_axis_tdata[15:0]),
    .write_data  (s_axis_tdata[23:16]),
    .port_a_pins (s_axis_tdata[31:24]),
    .vsync       (s_axis_tdata[32]),
    .strap       (strap),
    .result      (result)
  );

  ppi_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .taken      (m_axis_tready),
    .result_in  (result),
    .valid      (m_axis_tvalid),
    .result_out (result_q)
  );

  assign m_axis_tdata = {3'd0,
                         result_q.key_line,
                         result_q.key_line_valid,
                         result_q.psg_function,
                         result_q.psg_select_valid,
                         result_q.direction_flags,
                         result_q.port_c_latch,
                         result_q.port_b_latch,
                         result_q.port_a_latch,
                         result_q.read_data,
                         result_q.responded};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result register not empty after reset");

  a_unclaimed: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tdata[11] |=> m_axis_tvalid && !m_axis_tdata[0]
                                   && !m_axis_tdata[37] && !m_axis_tdata[40])
    else $error("unclaimed access produced a response");

  a_mode_clear: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tuser == ppi_pkg::OP_WRITE && !s_axis_tdata[11]
      && s_axis_tdata[9:8] == ppi_pkg::SEL_CTRL && s_axis_tdata[23]
    |=> m_axis_tdata[32:9] == '0)
    else $error("mode word did not clear the latches");

  a_strobe_claimed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[37] || m_axis_tdata[40]) |-> m_axis_tdata[0])
    else $error("strobe on an unclaimed access");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mode 0 parallel port interface. A short table
// of bus accesses covers the port reads, latch writes, control words and
// unclaimed addresses. Random accesses follow in phases that change the
// strap value and the idling on both streams. Every transaction on the
// result stream is compared field by field with a predictor kept here.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int ADDR_CLAIM_BIT = 11;
  localparam logic [7:0] CW_MODE_SET = 8'h80;
  localparam logic [7:0] CW_A_IN     = 8'h10;
  localparam logic [7:0] CW_CUP_IN   = 8'h08;
  localparam logic [7:0] CW_B_IN     = 8'h02;
  localparam logic [7:0] CW_CLOW_IN  = 8'h01;
  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 5;
  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    bit       op;
    bit [15:0] addr;
    bit [7:0] wdata;
    bit [7:0] pins;
    bit       vs;
    bit       typed;
    bit       resp;
    bit [7:0] rdata;
  } access_row_t;

  typedef struct {
    bit       responded;
    bit [7:0] read_data;
    bit [7:0] latch_a;
    bit [7:0] latch_b;
    bit [7:0] latch_c;
    bit [3:0] dirs;
    bit       psg_valid;
    bit [1:0] psg_func;
    bit       key_valid;
    bit [3:0] key_line;
    bit       typed;
    bit       typed_resp;
    bit [7:0] typed_rdata;
  } access_result_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ppi_pkg::IN_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ppi_pkg::OUT_W-1:0] m_axis_tdata;
  logic port_b_strap_we;
  logic [ppi_pkg::STRAP_W-1:0] port_b_strap;

  // Table expectations travel beside the transaction they belong to.
  logic row_typed;
  logic row_resp;
  logic [7:0] row_rdata;

  bit [ppi_pkg::STRAP_W-1:0] strap_value;
  bit [ppi_pkg::DIR_W-1:0] port_dirs;
  bit [7:0] out_latch_a;
  bit [7:0] out_latch_b;
  bit [7:0] out_latch_c;

  access_result_t pending_results [$];
  access_result_t oldest;
  access_result_t predicted;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  access_row_t directed_rows [N_DIRECTED] = '{
    '{ppi_pkg::OP_READ,  16'h0100, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'h5F},
    '{ppi_pkg::OP_READ,  16'h0100, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 8'h5E},
    '{ppi_pkg::OP_READ,  16'h0000, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00},
    '{ppi_pkg::OP_READ,  16'h0200, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
    '{ppi_pkg::OP_READ,  16'h0300, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00},
    '{ppi_pkg::OP_READ,  16'h0900, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h00FF, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0100, 8'h55, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0200, 8'hC7, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_READ,  16'h0200, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h0F, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h1E, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h9B, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_READ,  16'h0000, 8'h00, 8'hA5, 1'b0, 1'b1, 1'b1, 8'hA5},
    '{ppi_pkg::OP_READ,  16'h0200, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0200, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h0D, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h88, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0200, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'h81, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0200, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'hF2FF, 8'h3C, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{ppi_pkg::OP_WRITE, 16'h0300, 8'hE4, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  parallel_port_interface_mode0 DUT (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .port_b_strap_we (port_b_strap_we),
    .port_b_strap    (port_b_strap)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Decodes one bus access and updates the port state it changes.
  function automatic access_result_t decode_access(bit op, bit [15:0] addr, bit [7:0] wd,
                                                   bit [7:0] pins, bit vs);
    access_result_t r;
    r = '{default: 0};
    if (!addr[ADDR_CLAIM_BIT]) begin
      r.responded = 1'b1;
      if (op == ppi_pkg::OP_READ) begin
        case (addr[9:8])
          ppi_pkg::SEL_A: if (port_dirs[ppi_pkg::DIR_A]) r.read_data = pins;
          ppi_pkg::SEL_B: if (port_dirs[ppi_pkg::DIR_B]) r.read_data = {strap_value, vs};
          ppi_pkg::SEL_C: begin
            if (!port_dirs[ppi_pkg::DIR_C_UP] && !port_dirs[ppi_pkg::DIR_C_LOW])
              r.read_data = out_latch_c;
          end
          default: ;
        endcase
      end else begin
        case (addr[9:8])
          ppi_pkg::SEL_A: if (!port_dirs[ppi_pkg::DIR_A]) out_latch_a = wd;
          ppi_pkg::SEL_B: if (!port_dirs[ppi_pkg::DIR_B]) out_latch_b = wd;
          ppi_pkg::SEL_C: begin
            if (!port_dirs[ppi_pkg::DIR_C_UP]) begin
              out_latch_c[7:4] = wd[7:4];
              r.psg_valid = 1'b1;
              r.psg_func = wd[7:6];
            end
            if (!port_dirs[ppi_pkg::DIR_C_LOW]) begin
              out_latch_c[3:0] = wd[3:0];
              r.key_valid = 1'b1;
              r.key_line = wd[3:0];
            end
          end
          default: begin
            if ((wd & CW_MODE_SET) != 0) begin
              port_dirs[ppi_pkg::DIR_A] = (wd & CW_A_IN) != 0;
              port_dirs[ppi_pkg::DIR_C_UP] = (wd & CW_CUP_IN) != 0;
              port_dirs[ppi_pkg::DIR_B] = (wd & CW_B_IN) != 0;
              port_dirs[ppi_pkg::DIR_C_LOW] = (wd & CW_CLOW_IN) != 0;
              out_latch_a = '0;
              out_latch_b = '0;
              out_latch_c = '0;
            end else begin
              out_latch_c[wd[3:1]] = wd[0];
            end
          end
        endcase
      end
    end
    r.latch_a = out_latch_a;
    r.latch_b = out_latch_b;
    r.latch_c = out_latch_c;
    r.dirs = port_dirs;
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      strap_value = ppi_pkg::STRAP_RESET;
      port_dirs = ppi_pkg::DIR_RESET;
      out_latch_a = '0;
      out_latch_b = '0;
      out_latch_c = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          oldest = pending_results.pop_front();
          compare_field("responded", oldest.responded, m_axis_tdata[0]);
          compare_field("read_data", oldest.read_data, m_axis_tdata[8:1]);
          compare_field("port_a_latch", oldest.latch_a, m_axis_tdata[16:9]);
          compare_field("port_b_latch", oldest.latch_b, m_axis_tdata[24:17]);
          compare_field("port_c_latch", oldest.latch_c, m_axis_tdata[32:25]);
          compare_field("direction_flags", oldest.dirs, m_axis_tdata[36:33]);
          compare_field("psg_select_valid", oldest.psg_valid, m_axis_tdata[37]);
          compare_field("psg_function", oldest.psg_func, m_axis_tdata[39:38]);
          compare_field("key_line_valid", oldest.key_valid, m_axis_tdata[40]);
          compare_field("key_line", oldest.key_line, m_axis_tdata[44:41]);
          compare_field("padding", 0, m_axis_tdata[ppi_pkg::OUT_W-1:45]);
          if (oldest.typed) begin
            compare_field("responded (table)", oldest.typed_resp, m_axis_tdata[0]);
            compare_field("read_data (table)", oldest.typed_rdata, m_axis_tdata[8:1]);
          end
        end
      end
      if (port_b_strap_we) begin
        strap_value = port_b_strap;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = decode_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                                  s_axis_tdata[31:24], s_axis_tdata[32]);
        predicted.typed = row_typed;
        predicted.typed_resp = row_resp;
        predicted.typed_rdata = row_rdata;
        pending_results.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls at random and, when asked, holds off for a long stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_access(bit op, bit [15:0] addr, bit [7:0] wd, bit [7:0] pins, bit vs,
                             bit typed, bit resp, bit [7:0] rdata);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, vs, pins, wd, addr};
    row_typed <= typed;
    row_resp <= resp;
    row_rdata <= rdata;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random_access();
    bit op;
    bit [15:0] addr;
    bit [7:0] wd;
    op = 1'($urandom_range(1));
    addr = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 85) addr[ADDR_CLAIM_BIT] = 1'b0;
    wd = 8'($urandom_range(255));
    // Mode words clear every latch, so they are kept rare.
    if (op == ppi_pkg::OP_WRITE && addr[9:8] == ppi_pkg::SEL_CTRL)
      wd[7] = ($urandom_range(99) < 15);
    send_access(op, addr, wd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'b0, 1'b0, 8'h00);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_strap(bit [ppi_pkg::STRAP_W-1:0] value);
    @(negedge clk);
    port_b_strap_we <= 1'b1;
    port_b_strap <= value;
    @(negedge clk);
    port_b_strap_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    port_b_strap_we = 1'b0;
    port_b_strap = '0;
    row_typed = 1'b0;
    row_resp = 1'b0;
    row_rdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                  directed_rows[i].pins, directed_rows[i].vs, directed_rows[i].typed,
                  directed_rows[i].resp, directed_rows[i].rdata);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          write_strap('0);
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 0;
          write_strap('1);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 79;
          write_strap(ppi_pkg::STRAP_W'($urandom_range(127)));
        end
        3: begin
          send_idle_pct = 30;
          stall_pct = 30;
          write_strap(ppi_pkg::STRAP_W'($urandom_range(127)));
        end
        default: begin
          // The sender keeps offering while the receiver holds off.
          send_idle_pct = 0;
          stall_pct = 10;
          write_strap('1);
          hold_ticket++;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_access();
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
